FILE: hdl/c8afb_pkg.sv
// ----------------------------------------------------------------------------
// c8afb_pkg
// Shared types, constants and the CRC-8/ATM byte update for the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package c8afb_pkg;

    localparam int HEADER_BYTES   = 12;
    localparam int FRAME_OVERHEAD = HEADER_BYTES + 1;

    localparam logic [7:0]  PAYLOAD_CEIL = 8'd231;
    localparam logic [31:0] SEQ_MAX      = 32'h00FF_FFFF;
    localparam logic [7:0]  CRC_POLY     = 8'h07;

    // request kinds
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_HDR_REJ  = 2'd1;
    localparam status_t ST_NO_FRAME = 2'd2;

    // configuration register indexes
    typedef logic [2:0] cfg_addr_t;
    localparam cfg_addr_t CFG_MAGIC_ONE  = 3'd0;
    localparam cfg_addr_t CFG_MAGIC_TWO  = 3'd1;
    localparam cfg_addr_t CFG_VERSION    = 3'd2;
    localparam cfg_addr_t CFG_TYPE_LO    = 3'd3;
    localparam cfg_addr_t CFG_TYPE_HI    = 3'd4;
    localparam cfg_addr_t CFG_PAY_LIMIT  = 3'd5;
    localparam cfg_addr_t CFG_CAPACITY   = 3'd6;

    // emission step within one item; header byte order then the CRC byte
    typedef logic [3:0] step_t;
    localparam step_t HB_MAGIC_ONE = 4'd0;
    localparam step_t HB_MAGIC_TWO = 4'd1;
    localparam step_t HB_VERSION   = 4'd2;
    localparam step_t HB_TYPE      = 4'd3;
    localparam step_t HB_SESS_LO   = 4'd4;
    localparam step_t HB_SESS_HI   = 4'd5;
    localparam step_t HB_SEQ_B0    = 4'd6;
    localparam step_t HB_SEQ_B1    = 4'd7;
    localparam step_t HB_SEQ_B2    = 4'd8;
    localparam step_t HB_INDEX     = 4'd9;
    localparam step_t HB_COUNT     = 4'd10;
    localparam step_t HB_LENGTH    = 4'd11;
    localparam step_t HB_CRC       = 4'd12;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  payload_length;
        logic [7:0]  fragment_count;
        logic [7:0]  fragment_index;
        logic [31:0] sequence_number;
        logic [15:0] session_id;
        logic [7:0]  frame_type;
    } item_data_t;

    typedef struct packed {
        logic [7:0] magic_byte_one;
        logic [7:0] magic_byte_two;
        logic [7:0] protocol_version;
        logic [7:0] type_lowest;
        logic [7:0] type_highest;
        logic [7:0] payload_limit;
        logic [9:0] frame_capacity;
    } cfg_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/c8afb_hdr_check.sv
// ----------------------------------------------------------------------------
// c8afb_hdr_check
// Header request validation against the configured limits; also gives the
// total frame length of an accepted header.
// ----------------------------------------------------------------------------
`default_nettype none

module c8afb_hdr_check (
    input  var c8afb_pkg::item_data_t item,
    input  var c8afb_pkg::cfg_t       cfg,
    output logic                      hdr_ok,
    output logic [7:0]                frame_len
);

    logic [7:0] limit;
    logic [8:0] flen;

    assign limit = (cfg.payload_limit > c8afb_pkg::PAYLOAD_CEIL) ?
                   c8afb_pkg::PAYLOAD_CEIL : cfg.payload_limit;
    assign flen  = {1'b0, item.payload_length} + 9'(c8afb_pkg::FRAME_OVERHEAD);

    assign hdr_ok = (item.frame_type >= cfg.type_lowest) &&
                    (item.frame_type <= cfg.type_highest) &&
                    (item.session_id != 16'd0) &&
                    (item.sequence_number <= c8afb_pkg::SEQ_MAX) &&
                    (item.fragment_count != 8'd0) &&
                    (item.fragment_index < item.fragment_count) &&
                    (item.payload_length <= limit) &&
                    ({1'b0, flen} <= cfg.frame_capacity);

    assign frame_len = flen[7:0];

endmodule

`default_nettype wire

FILE: hdl/crc8_audio_frame_builder.sv
// ----------------------------------------------------------------------------
// crc8_audio_frame_builder
// Byte-stream serializer for CRC-8/ATM protected frames: header requests
// expand into 12 header bytes, payload bytes pass through, a CRC byte closes.
//
//   channel | dir | tdata                               | tuser     | tlast
//   s_      | in  | type,session,seq,idx,cnt,len,byte   | req_type  | -
//   m_      | out | out_byte,frame_length               | status    | end_of_frame
//   cfg_    | in  | write enable, 3-bit index, 10-bit data
//
// One beat in per cycle for payload bytes while the output takes beats; the last
// payload byte gives the data byte, then the CRC byte. A valid header gives 12
// header bytes, then the CRC byte when the payload length is zero. A rejected request gives one status beat. The single
// result emitter sets the rate; one output register parts the two sides.
// Synchronous active-low reset clears the frame state and loads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_audio_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] frame_type, [23:8] session_id, [55:24] sequence_number,
    // [63:56] fragment_index, [71:64] fragment_count, [79:72] payload_length,
    // [87:80] payload_byte
    input  logic [87:0] s_tdata,
    // [0] req_type
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [15:8] frame_length
    output logic [15:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tlast,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);

    c8afb_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_byte_one   <= 8'd0;
            cfg_reg.magic_byte_two   <= 8'd0;
            cfg_reg.protocol_version <= 8'd0;
            cfg_reg.type_lowest      <= 8'd0;
            cfg_reg.type_highest     <= 8'd3;
            cfg_reg.payload_limit    <= 8'd231;
            cfg_reg.frame_capacity   <= 10'd244;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                c8afb_pkg::CFG_MAGIC_ONE: cfg_reg.magic_byte_one   <= cfg_wdata[7:0];
                c8afb_pkg::CFG_MAGIC_TWO: cfg_reg.magic_byte_two   <= cfg_wdata[7:0];
                c8afb_pkg::CFG_VERSION:   cfg_reg.protocol_version <= cfg_wdata[7:0];
                c8afb_pkg::CFG_TYPE_LO:   cfg_reg.type_lowest      <= cfg_wdata[7:0];
                c8afb_pkg::CFG_TYPE_HI:   cfg_reg.type_highest     <= cfg_wdata[7:0];
                c8afb_pkg::CFG_PAY_LIMIT: cfg_reg.payload_limit    <= cfg_wdata[7:0];
                c8afb_pkg::CFG_CAPACITY:  cfg_reg.frame_capacity   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // held item
    logic                  held_valid_reg;
    logic                  held_req_reg;
    c8afb_pkg::item_data_t held_reg;

    // frame state
    logic                  open_reg, open_next;
    logic [7:0]            rem_reg, rem_next;
    logic [7:0]            crc_reg, crc_next;
    logic [7:0]            tot_reg, tot_next;
    c8afb_pkg::step_t      step_reg, step_next;

    // output register
    logic                  m_valid_reg;
    logic [7:0]            ob_reg;
    logic [7:0]            flen_reg;
    c8afb_pkg::status_t    st_reg;
    logic                  eof_reg;

    logic                  hdr_ok;
    logic [7:0]            hdr_len;
    logic                  emit_en;
    logic                  last;
    logic                  in_accept;
    logic [7:0]            ob;
    logic [7:0]            flen_o;
    c8afb_pkg::status_t    st;
    logic                  eof;
    logic [7:0]            hbyte;
    logic [7:0]            crc_base;

    c8afb_hdr_check u_hdr_check (
        .item      (held_reg),
        .cfg       (cfg_reg),
        .hdr_ok    (hdr_ok),
        .frame_len (hdr_len)
    );

    assign emit_en   = held_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !held_valid_reg || (emit_en && last);
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        case (step_reg)
            c8afb_pkg::HB_MAGIC_ONE: hbyte = cfg_reg.magic_byte_one;
            c8afb_pkg::HB_MAGIC_TWO: hbyte = cfg_reg.magic_byte_two;
            c8afb_pkg::HB_VERSION:   hbyte = cfg_reg.protocol_version;
            c8afb_pkg::HB_TYPE:      hbyte = held_reg.frame_type;
            c8afb_pkg::HB_SESS_LO:   hbyte = held_reg.session_id[7:0];
            c8afb_pkg::HB_SESS_HI:   hbyte = held_reg.session_id[15:8];
            c8afb_pkg::HB_SEQ_B0:    hbyte = held_reg.sequence_number[7:0];
            c8afb_pkg::HB_SEQ_B1:    hbyte = held_reg.sequence_number[15:8];
            c8afb_pkg::HB_SEQ_B2:    hbyte = held_reg.sequence_number[23:16];
            c8afb_pkg::HB_INDEX:     hbyte = held_reg.fragment_index;
            c8afb_pkg::HB_COUNT:     hbyte = held_reg.fragment_count;
            c8afb_pkg::HB_LENGTH:    hbyte = held_reg.payload_length;
            default:                 hbyte = 8'h00;
        endcase
    end

    assign crc_base = (step_reg == c8afb_pkg::HB_MAGIC_ONE) ? 8'h00 : crc_reg;

    always_comb begin
        ob        = 8'h00;
        flen_o    = 8'h00;
        st        = c8afb_pkg::ST_OK;
        eof       = 1'b0;
        last      = 1'b1;
        open_next = open_reg;
        rem_next  = rem_reg;
        crc_next  = crc_reg;
        tot_next  = tot_reg;
        step_next = step_reg;
        if (held_req_reg == c8afb_pkg::REQ_PAYLOAD) begin
            if (step_reg != c8afb_pkg::HB_MAGIC_ONE) begin
                // CRC byte after the last payload byte
                ob        = crc_reg;
                eof       = 1'b1;
                flen_o    = tot_reg;
                open_next = 1'b0;
                rem_next  = 8'd0;
                crc_next  = 8'd0;
                tot_next  = 8'd0;
            end else if (!open_reg || rem_reg == 8'd0) begin
                st  = c8afb_pkg::ST_NO_FRAME;
                eof = 1'b1;
            end else begin
                ob       = held_reg.payload_byte;
                crc_next = c8afb_pkg::crc8_byte(crc_reg, held_reg.payload_byte);
                rem_next = rem_reg - 8'd1;
                if (rem_reg == 8'd1) begin
                    last      = 1'b0;
                    step_next = c8afb_pkg::HB_MAGIC_TWO;
                end
            end
        end else begin
            if (step_reg == c8afb_pkg::HB_MAGIC_ONE && !hdr_ok) begin
                st  = c8afb_pkg::ST_HDR_REJ;
                eof = 1'b1;
            end else if (step_reg == c8afb_pkg::HB_CRC) begin
                ob        = crc_reg;
                eof       = 1'b1;
                flen_o    = tot_reg;
                open_next = 1'b0;
                rem_next  = 8'd0;
                crc_next  = 8'd0;
                tot_next  = 8'd0;
            end else begin
                ob        = hbyte;
                crc_next  = c8afb_pkg::crc8_byte(crc_base, hbyte);
                last      = 1'b0;
                step_next = c8afb_pkg::step_t'(step_reg + 4'd1);
                if (step_reg == c8afb_pkg::HB_MAGIC_ONE) begin
                    open_next = 1'b1;
                    tot_next  = hdr_len;
                    rem_next  = held_reg.payload_length;
                end
                if (step_reg == c8afb_pkg::HB_LENGTH &&
                    held_reg.payload_length != 8'd0) begin
                    last = 1'b1;
                end
            end
        end
        if (last) begin
            step_next = c8afb_pkg::HB_MAGIC_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            rem_reg        <= 8'd0;
            crc_reg        <= 8'd0;
            tot_reg        <= 8'd0;
            step_reg       <= c8afb_pkg::HB_MAGIC_ONE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_accept) begin
                held_valid_reg <= 1'b1;
            end else if (emit_en && last) begin
                held_valid_reg <= 1'b0;
            end
            if (emit_en) begin
                open_reg    <= open_next;
                rem_reg     <= rem_next;
                crc_reg     <= crc_next;
                tot_reg     <= tot_next;
                step_reg    <= step_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            held_req_reg <= s_tuser[0];
            held_reg     <= c8afb_pkg::item_data_t'(s_tdata);
        end
        if (emit_en) begin
            ob_reg   <= ob;
            flen_reg <= flen_o;
            st_reg   <= st;
            eof_reg  <= eof;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {flen_reg, ob_reg};
    assign m_tuser  = st_reg;
    assign m_tlast  = eof_reg;

endmodule

`default_nettype wire

FILE: verif/crc8_audio_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// crc8_audio_frame_builder_tb
// Self-checking bench for the CRC-8/ATM frame serializer. A queue-fed driver
// streams header and payload requests. A predictor runs at each accepted input
// beat and queues the frame bytes and status beats it should produce. A monitor
// checks every output beat against that queue. The run covers directed corner
// cases, a long output stall that backs up the input, several register
// settings with their extremes, and a random mix of well-formed and broken
// frames.
// ----------------------------------------------------------------------------
module crc8_audio_frame_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic                   req;
        c8afb_pkg::item_data_t  d;
    } tx_beat_t;

    typedef struct packed {
        logic [7:0]         octet;
        logic               last;
        c8afb_pkg::status_t st;
        logic [7:0]         flen;
    } frame_beat_t;

    typedef enum {
        BREAK_TYPE_LO, BREAK_TYPE_HI, BREAK_SESSION, BREAK_SEQ,
        BREAK_COUNT, BREAK_INDEX, BREAK_LIMIT, BREAK_CAPACITY
    } hdr_fault_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [9:0]  cfg_wdata = '0;

    crc8_audio_frame_builder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // register shadow, serializer state
    c8afb_pkg::cfg_t link_cfg = '{magic_byte_one: 8'd0, magic_byte_two: 8'd0,
                                  protocol_version: 8'd0, type_lowest: 8'd0,
                                  type_highest: 8'd3, payload_limit: 8'd231,
                                  frame_capacity: 10'd244};
    logic       fr_open  = 1'b0;
    logic [7:0] fr_left  = '0;
    logic [7:0] fr_crc   = '0;
    logic [7:0] fr_total = '0;

    tx_beat_t    tx_pending[$];
    frame_beat_t frame_beats_due[$];
    tx_beat_t    tx_cur;

    int   items_queued = 0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;
    int   tx_gap       = 0;
    int   rx_gap       = 0;
    logic tx_quiet     = 1'b0;
    logic rx_quiet     = 1'b0;
    logic calm         = 1'b0;

    logic rx_hold_go    = 1'b0;
    logic rx_hold_done  = 1'b0;
    int   rx_hold_count = 0;
    logic rx_holding;

    assign rx_holding = rx_hold_go && !rx_hold_done;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] crc8_atm_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? c8afb_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void push_beat(input logic [7:0] octet, input logic last,
                                      input c8afb_pkg::status_t st, input logic [7:0] flen);
        frame_beat_t fb;
        fb.octet = octet;
        fb.last  = last;
        fb.st    = st;
        fb.flen  = flen;
        frame_beats_due.push_back(fb);
    endfunction

    function automatic void emit_frame_byte(input logic [7:0] b);
        push_beat(b, 1'b0, c8afb_pkg::ST_OK, 8'd0);
        fr_crc = crc8_atm_step(fr_crc, b);
    endfunction

    function automatic void emit_crc_byte();
        push_beat(fr_crc, 1'b1, c8afb_pkg::ST_OK, fr_total);
        fr_open  = 1'b0;
        fr_left  = '0;
        fr_crc   = '0;
        fr_total = '0;
    endfunction

    function automatic void serialize_request(input tx_beat_t r);
        c8afb_pkg::item_data_t d;
        logic [7:0]            lim;
        logic [9:0]            flen;
        logic                  ok;
        d = r.d;
        if (r.req == c8afb_pkg::REQ_PAYLOAD) begin
            if (!fr_open || fr_left == 8'd0) begin
                push_beat(8'd0, 1'b1, c8afb_pkg::ST_NO_FRAME, 8'd0);
            end else begin
                emit_frame_byte(d.payload_byte);
                fr_left = fr_left - 8'd1;
                if (fr_left == 8'd0) emit_crc_byte();
            end
        end else begin
            lim  = (link_cfg.payload_limit > c8afb_pkg::PAYLOAD_CEIL) ?
                   c8afb_pkg::PAYLOAD_CEIL : link_cfg.payload_limit;
            flen = 10'(d.payload_length) + 10'(c8afb_pkg::FRAME_OVERHEAD);
            ok   = (d.frame_type >= link_cfg.type_lowest) &&
                   (d.frame_type <= link_cfg.type_highest) &&
                   (d.session_id != 16'd0) &&
                   (d.sequence_number <= c8afb_pkg::SEQ_MAX) &&
                   (d.fragment_count != 8'd0) && (d.fragment_index < d.fragment_count) &&
                   (d.payload_length <= lim) && (flen <= link_cfg.frame_capacity);
            if (!ok) begin
                push_beat(8'd0, 1'b1, c8afb_pkg::ST_HDR_REJ, 8'd0);
            end else begin
                // a valid header drops any open frame without its CRC
                fr_open  = 1'b1;
                fr_crc   = '0;
                fr_total = flen[7:0];
                fr_left  = d.payload_length;
                emit_frame_byte(link_cfg.magic_byte_one);
                emit_frame_byte(link_cfg.magic_byte_two);
                emit_frame_byte(link_cfg.protocol_version);
                emit_frame_byte(d.frame_type);
                emit_frame_byte(d.session_id[7:0]);
                emit_frame_byte(d.session_id[15:8]);
                emit_frame_byte(d.sequence_number[7:0]);
                emit_frame_byte(d.sequence_number[15:8]);
                emit_frame_byte(d.sequence_number[23:16]);
                emit_frame_byte(d.fragment_index);
                emit_frame_byte(d.fragment_count);
                emit_frame_byte(d.payload_length);
                if (d.payload_length == 8'd0) emit_crc_byte();
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) serialize_request(tx_cur);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (tx_pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && !tx_quiet && $urandom_range(7, 0) == 0) begin
                    tx_gap   <= int'($urandom_range(10, 0));
                    s_tvalid <= 1'b0;
                end else begin
                    tx_cur = tx_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_cur.d;
                    s_tuser  <= tx_cur.req;
                end
            end
            if ($urandom_range(63, 0) == 0) tx_quiet <= !tx_quiet;
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------------
    function automatic void note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        frame_beat_t got;
        frame_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.octet = m_tdata[7:0];
                got.flen  = m_tdata[15:8];
                got.st    = m_tuser;
                got.last  = m_tlast;
                if (frame_beats_due.size() == 0) begin
                    note_error($sformatf("unexpected beat: byte %h last %b status %0d len %0d",
                                         got.octet, got.last, got.st, got.flen));
                end else begin
                    want = frame_beats_due.pop_front();
                    if (got.octet !== want.octet || got.last !== want.last ||
                        got.st !== want.st || got.flen !== want.flen)
                        note_error($sformatf(
                            "beat mismatch (exp/got): byte %h/%h last %b/%b st %0d/%0d len %0d/%0d",
                            want.octet, got.octet, want.last, got.last, want.st, got.st,
                            want.flen, got.flen));
                end
            end
            if (rx_holding) begin
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && !rx_quiet && $urandom_range(9, 0) == 0) begin
                rx_gap   <= int'($urandom_range(10, 0));
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(63, 0) == 0) rx_quiet <= !rx_quiet;
        end
    end

    // long output stall
    always @(posedge aclk) begin
        if (rx_hold_go && !rx_hold_done) begin
            if (rx_hold_count == HOLD_CYCLES - 1) rx_hold_done <= 1'b1;
            rx_hold_count <= rx_hold_count + 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (tx_pending.size() == 0 && !s_tvalid && frame_beats_due.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("** crc8_audio_frame_builder: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic void push_item(input tx_beat_t b);
        tx_pending.push_back(b);
        items_queued++;
    endfunction

    function automatic tx_beat_t make_header(input logic [7:0] ftype, input logic [15:0] sess,
                                             input logic [31:0] seq, input logic [7:0] idx,
                                             input logic [7:0] cnt, input logic [7:0] len);
        tx_beat_t r;
        r.req               = c8afb_pkg::REQ_HEADER;
        r.d.frame_type      = ftype;
        r.d.session_id      = sess;
        r.d.sequence_number = seq;
        r.d.fragment_index  = idx;
        r.d.fragment_count  = cnt;
        r.d.payload_length  = len;
        r.d.payload_byte    = 8'($urandom_range(255, 0));
        return r;
    endfunction

    function automatic tx_beat_t make_payload(input logic [7:0] b);
        tx_beat_t r;
        r.req            = c8afb_pkg::REQ_PAYLOAD;
        r.d              = 88'({$urandom(), $urandom(), $urandom()});
        r.d.payload_byte = b;
        return r;
    endfunction

    function automatic int valid_len_max();
        int lim;
        int room;
        lim  = (link_cfg.payload_limit > c8afb_pkg::PAYLOAD_CEIL) ?
               int'(c8afb_pkg::PAYLOAD_CEIL) : int'(link_cfg.payload_limit);
        room = int'(link_cfg.frame_capacity) - c8afb_pkg::FRAME_OVERHEAD;
        return (room < lim) ? room : lim;
    endfunction

    function automatic int pick_len();
        int mx;
        mx = valid_len_max();
        if (mx < 0) mx = 0;
        if ($urandom_range(15, 0) == 0) return int'($urandom_range((mx < 40) ? mx : 40, 0));
        return int'($urandom_range((mx < 6) ? mx : 6, 0));
    endfunction

    function automatic void send_frame(input int len, input int keep);
        logic [7:0] cnt;
        cnt = 8'($urandom_range(255, 1));
        push_item(make_header(8'($urandom_range(link_cfg.type_highest, link_cfg.type_lowest)),
                              16'($urandom_range(65535, 1)),
                              32'($urandom_range(c8afb_pkg::SEQ_MAX, 0)),
                              8'($urandom_range(cnt - 8'd1, 0)), cnt, 8'(len)));
        repeat (keep) push_item(make_payload(8'($urandom_range(255, 0))));
    endfunction

    function automatic void send_bad_header();
        logic [7:0]  ft;
        logic [7:0]  idx;
        logic [7:0]  cnt;
        logic [7:0]  len;
        logic [15:0] sess;
        logic [31:0] seq;
        int          mx;
        int          cap;
        hdr_fault_t  fault;
        mx    = valid_len_max();
        cap   = int'(link_cfg.frame_capacity);
        ft    = 8'($urandom_range(link_cfg.type_highest, link_cfg.type_lowest));
        sess  = 16'($urandom_range(65535, 1));
        seq   = 32'($urandom_range(c8afb_pkg::SEQ_MAX, 0));
        cnt   = 8'($urandom_range(255, 1));
        idx   = 8'($urandom_range(cnt - 8'd1, 0));
        len   = 8'($urandom_range((mx < 0) ? 0 : mx, 0));
        fault = hdr_fault_t'($urandom_range(7, 0));
        case (fault)
            BREAK_TYPE_LO: begin
                if (link_cfg.type_lowest != 8'd0)
                    ft = 8'($urandom_range(link_cfg.type_lowest - 8'd1, 0));
                else sess = '0;
            end
            BREAK_TYPE_HI: begin
                if (link_cfg.type_highest != 8'd255)
                    ft = 8'($urandom_range(255, int'(link_cfg.type_highest) + 1));
                else sess = '0;
            end
            BREAK_SESSION: sess = '0;
            BREAK_SEQ:     seq[31:24] = 8'($urandom_range(255, 1));
            BREAK_COUNT: begin
                cnt = '0;
                idx = 8'($urandom_range(255, 0));
            end
            BREAK_INDEX:   idx = 8'($urandom_range(255, cnt));
            BREAK_LIMIT:   len = 8'($urandom_range(255, valid_len_max() + 1));
            BREAK_CAPACITY: begin
                if (cap < 268) len = 8'($urandom_range(255, (cap >= 13) ? cap - 12 : 0));
                else sess = '0;
            end
            default: sess = '0;
        endcase
        push_item(make_header(ft, sess, seq, idx, cnt, len));
    endfunction

    task automatic random_traffic(input int n);
        int goal;
        int len;
        int keep;
        int pick;
        goal = items_queued + n;
        while (items_queued < goal) begin
            pick = int'($urandom_range(99, 0));
            len  = pick_len();
            if (pick < 65) begin
                send_frame(len, len);
            end else if (pick < 75) begin
                send_frame(len, int'($urandom_range(len, 0)));
            end else if (pick < 85) begin
                send_bad_header();
            end else if (pick < 93) begin
                push_item(make_payload(8'($urandom_range(255, 0))));
            end else begin
                // rejected header in the middle of an open frame
                keep = int'($urandom_range(len, 0));
                send_frame(len, keep);
                send_bad_header();
                repeat (len - keep) push_item(make_payload(8'($urandom_range(255, 0))));
            end
        end
    endtask

    task automatic write_reg(input c8afb_pkg::cfg_addr_t idx, input logic [9:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            c8afb_pkg::CFG_MAGIC_ONE: link_cfg.magic_byte_one   = val[7:0];
            c8afb_pkg::CFG_MAGIC_TWO: link_cfg.magic_byte_two   = val[7:0];
            c8afb_pkg::CFG_VERSION:   link_cfg.protocol_version = val[7:0];
            c8afb_pkg::CFG_TYPE_LO:   link_cfg.type_lowest      = val[7:0];
            c8afb_pkg::CFG_TYPE_HI:   link_cfg.type_highest     = val[7:0];
            c8afb_pkg::CFG_PAY_LIMIT: link_cfg.payload_limit    = val[7:0];
            c8afb_pkg::CFG_CAPACITY:  link_cfg.frame_capacity   = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [9:0] m1, input logic [9:0] m2, input logic [9:0] ver,
                               input logic [9:0] lo, input logic [9:0] hi,
                               input logic [9:0] lim, input logic [9:0] cap);
        write_reg(c8afb_pkg::CFG_MAGIC_ONE, m1);
        write_reg(c8afb_pkg::CFG_MAGIC_TWO, m2);
        write_reg(c8afb_pkg::CFG_VERSION, ver);
        write_reg(c8afb_pkg::CFG_TYPE_LO, lo);
        write_reg(c8afb_pkg::CFG_TYPE_HI, hi);
        write_reg(c8afb_pkg::CFG_PAY_LIMIT, lim);
        write_reg(c8afb_pkg::CFG_CAPACITY, cap);
    endtask

    task automatic random_config();
        int lo;
        int hi;
        lo = int'($urandom_range(200, 0));
        hi = lo + int'($urandom_range(55, 0));
        load_config(10'($urandom_range(255, 0)), 10'($urandom_range(255, 0)),
                    10'($urandom_range(255, 0)), 10'(lo), 10'(hi),
                    10'($urandom_range(255, 0)), 10'($urandom_range(1023, 13)));
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (tx_pending.size() != 0 || s_tvalid || frame_beats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults: stray byte, empty frame, field extremes, reject causes other than low type and capacity
        push_item(make_payload(8'hFF));
        push_item(make_header(8'd0, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd3, 16'hFFFF, 32'h00FF_FFFF, 8'd254, 8'd255, 8'd2));
        push_item(make_payload(8'h00));
        push_item(make_payload(8'hFF));
        push_item(make_header(8'd4, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd0, 16'd0, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd1, 16'd5, 32'h0100_0000, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd1, 16'd5, 32'd1, 8'd0, 8'd0, 8'd0));
        push_item(make_header(8'd1, 16'd5, 32'd1, 8'd7, 8'd7, 8'd0));
        push_item(make_header(8'd1, 16'd5, 32'd1, 8'd0, 8'd1, 8'd232));
        // new header abandons an open frame
        push_item(make_header(8'd2, 16'd9, 32'd2, 8'd0, 8'd2, 8'd3));
        push_item(make_payload(8'h5A));
        push_item(make_header(8'd2, 16'd9, 32'd3, 8'd1, 8'd2, 8'd1));
        push_item(make_payload(8'hA5));
        // rejected header leaves the open frame alone
        push_item(make_header(8'd1, 16'd7, 32'd4, 8'd0, 8'd1, 8'd2));
        push_item(make_payload(8'h11));
        push_item(make_header(8'd255, 16'd7, 32'd5, 8'd0, 8'd1, 8'd0));
        push_item(make_payload(8'h22));
        push_item(make_payload(8'h33));
        wait_drained();

        // all-ones markers, full type range, limit above the ceiling
        load_config(10'hFF, 10'hFF, 10'hFF, 10'd0, 10'd255, 10'd255, 10'h3FF);
        push_item(make_header(8'd255, 16'd1, 32'h00FF_FFFF, 8'd0, 8'd1, 8'd232));
        push_item(make_header(8'd7, 16'd1, 32'd1, 8'd0, 8'd1, 8'd231));
        push_item(make_header(8'd0, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        wait_drained();
        // long frame while the output is held off
        @(posedge aclk);
        rx_hold_go <= 1'b1;
        @(negedge aclk);
        push_item(make_header(8'd128, 16'hBEEF, 32'h0012_3456, 8'd3, 8'd4, 8'd50));
        repeat (50) push_item(make_payload(8'($urandom_range(255, 0))));
        wait_drained();

        // tight capacity
        load_config(10'h00, 10'h00, 10'h80, 10'd5, 10'd9, 10'd10, 10'd20);
        send_frame(7, 7);
        push_item(make_header(8'd5, 16'd1, 32'd0, 8'd0, 8'd1, 8'd8));
        random_traffic(40);
        wait_drained();

        // inverted type bounds reject everything
        write_reg(c8afb_pkg::CFG_TYPE_LO, 10'd200);
        write_reg(c8afb_pkg::CFG_TYPE_HI, 10'd100);
        push_item(make_header(8'd100, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd150, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd200, 16'd1, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_payload(8'h44));
        wait_drained();
        write_reg(c8afb_pkg::CFG_TYPE_LO, 10'd0);
        write_reg(c8afb_pkg::CFG_TYPE_HI, 10'd255);
        write_reg(c8afb_pkg::CFG_PAY_LIMIT, 10'd0);
        push_item(make_header(8'd9, 16'd2, 32'd0, 8'd0, 8'd1, 8'd0));
        push_item(make_header(8'd9, 16'd2, 32'd1, 8'd0, 8'd1, 8'd1));
        wait_drained();
        write_reg(c8afb_pkg::CFG_CAPACITY, 10'd0);
        push_item(make_header(8'd9, 16'd2, 32'd2, 8'd0, 8'd1, 8'd0));
        wait_drained();

        repeat (2) begin
            random_config();
            random_traffic(30);
            wait_drained();
        end
        random_config();
        calm = 1'b1;
        random_traffic(40);
        wait_drained();

        if (mismatches == 0) begin
            $display("** crc8_audio_frame_builder: PASSED **");
        end else begin
            $display("** crc8_audio_frame_builder: FAILED **");
        end
        $finish;
    end

endmodule
